// ===== rtl/core/led_bar_vu_meter_peak_hold_unit_defines.svh =====
// ---------------------------------------------------------------------------
// LED bar VU meter assertion macros
// Shared concurrent assertion forms for the VU meter checker.
// ---------------------------------------------------------------------------
`ifndef LED_BAR_VU_METER_PEAK_HOLD_UNIT_DEFINES_SVH
`define LED_BAR_VU_METER_PEAK_HOLD_UNIT_DEFINES_SVH

// same-cycle implication, held off during reset
`define LBVU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbvu assertion failed");

// next-cycle implication, held off during reset
`define LBVU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbvu assertion failed");

`endif

// ===== rtl/core/lbvu_pkg.sv =====
// ---------------------------------------------------------------------------
// LED bar VU meter package
// Register indexes, reset values, frame context type and height scaling.
// ---------------------------------------------------------------------------
package lbvu_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_IDX_CENTRED   = 2'd0;
    localparam logic [1:0] CFG_IDX_FALL_EN   = 2'd1;
    localparam logic [1:0] CFG_IDX_FALL_RATE = 2'd2;

    localparam logic [7:0] HUE_RESET       = 8'd30;
    localparam logic [7:0] FALL_RATE_RESET = 8'd4;
    localparam logic [7:0] HUE_STEP        = 8'd10;

    // level*72/500 == (level*18)/125; divide by 125 via reciprocal 16778 >> 21,
    // exact for every product below 21399 (ours tops out at 18414)
    localparam logic [14:0] HEIGHT_RECIP = 15'd16778;
    localparam int          HEIGHT_SHIFT = 21;

    // per-frame drawing context, latched when a frame starts
    typedef struct packed {
        logic       centred;
        logic [7:0] height;
        logic [7:0] peak;
        logic       peak_ok;   // peak dot is drawn
        logic [7:0] hue_base;
    } frame_t;

    function automatic logic [7:0] calc_height(input logic [9:0] level);
        logic [14:0] x;
        logic [29:0] prod;
        begin
            x    = {1'b0, level, 4'b0000} + {4'b0000, level, 1'b0};
            prod = x * HEIGHT_RECIP;
            calc_height = prod[HEIGHT_SHIFT+7:HEIGHT_SHIFT];
        end
    endfunction

endpackage

// ===== rtl/core/led_bar_vu_meter_peak_hold_unit.sv =====
// ---------------------------------------------------------------------------
// LED bar VU meter with peak hold
// Turns one microphone level per request into one coloured result per LED.
// ---------------------------------------------------------------------------
// A request passes the input buffer, then the frame context register, then
//   the output register. One LED result per cycle while the output side does
//   not stall, set by the single per-LED colour path stepping through the strip.
// One input request is buffered while a frame streams out, so frames run
//   back to back with no gap when the output side never stalls.
// Reset: asynchronous, active low; peak 0, fall counter 0, hue base 30,
//   centred mode off, peak fall on, fall rate 4.
module led_bar_vu_meter_peak_hold_unit #(
    parameter int LED_COUNT = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration writes
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [9:0] mic_level, [15:10] zero
    input  logic        s_tuser,    // [0] hue_tick
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [5:0] led_position, [13:6] hue, [15:14] zero
    output logic        m_tuser,    // [0] lit
    output logic        m_tlast     // last_led
);

    localparam int PW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam logic [PW-1:0] LAST_P    = PW'(LED_COUNT - 1);
    localparam logic [7:0]    LIMIT_ALL = 8'(LED_COUNT);
    localparam logic [7:0]    LIMIT_MID = 8'(LED_COUNT / 2);

    // -----------------------------------------------------------------------
    // configuration registers
    // -----------------------------------------------------------------------
    logic       cfg_centred_reg;
    logic       cfg_fall_en_reg;
    logic [7:0] cfg_fall_rate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_centred_reg   <= 1'b0;
            cfg_fall_en_reg   <= 1'b1;
            cfg_fall_rate_reg <= lbvu_pkg::FALL_RATE_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                lbvu_pkg::CFG_IDX_CENTRED:   cfg_centred_reg   <= cfg_wdata[0];
                lbvu_pkg::CFG_IDX_FALL_EN:   cfg_fall_en_reg   <= cfg_wdata[0];
                lbvu_pkg::CFG_IDX_FALL_RATE: cfg_fall_rate_reg <= cfg_wdata;
                default: ;   // unmapped index, write dropped
            endcase
        end
    end

    // -----------------------------------------------------------------------
    // input buffer: holds one request; bar height worked out on the way in
    // -----------------------------------------------------------------------
    logic       pend_valid_reg, pend_valid_next;
    logic [7:0] pend_height_reg;
    logic       pend_tick_reg;
    logic       in_take;

    assign s_tready = !pend_valid_reg;
    assign in_take  = s_tvalid && s_tready;

    // -----------------------------------------------------------------------
    // frame sequencer
    // -----------------------------------------------------------------------
    logic          active_reg, active_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic          out_free;
    logic          step;
    logic          last_pos;
    logic          load;

    lbvu_pkg::frame_t frame_reg, frame_next;

    // persistent state
    logic [7:0] held_peak_reg, held_peak_next;
    logic [7:0] fall_cnt_reg, fall_cnt_next;
    logic [7:0] hue_base_reg, hue_base_next;

    // frame-start arithmetic
    logic [7:0] peak_draw;
    logic [7:0] hue_new;
    logic [7:0] limit;
    logic [8:0] fall_cnt_inc;

    // output register
    logic       out_valid_reg, out_valid_next;
    logic [5:0] out_pos_reg;
    logic       out_lit_reg;
    logic [7:0] out_hue_reg;
    logic       out_last_reg;

    logic       px_lit;
    logic [7:0] px_hue;

    assign out_free = !out_valid_reg || m_tready;
    assign step     = active_reg && out_free;
    assign last_pos = pos_reg == LAST_P;
    // start a new frame when idle, or straight after the last LED of this one
    assign load     = pend_valid_reg && (!active_reg || (step && last_pos));

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (in_take)
            pend_valid_next = 1'b1;
        else if (load)
            pend_valid_next = 1'b0;
    end

    always_comb
    begin
        active_next = active_reg;
        pos_next    = pos_reg;
        if (load)
        begin
            active_next = 1'b1;
            pos_next    = '0;
        end
        else if (step)
        begin
            active_next = !last_pos;
            pos_next    = pos_reg + PW'(1);
        end
    end

    // frame start: peak max and hue advance feed the drawing; the decay only
    // matters to the next frame, so it is applied here as well
    always_comb
    begin
        peak_draw    = (pend_height_reg > held_peak_reg) ? pend_height_reg : held_peak_reg;
        hue_new      = hue_base_reg + 8'(pend_tick_reg);
        limit        = cfg_centred_reg ? LIMIT_MID : LIMIT_ALL;
        fall_cnt_inc = {1'b0, fall_cnt_reg} + 9'd1;

        frame_next.centred  = cfg_centred_reg;
        frame_next.height   = pend_height_reg;
        frame_next.peak     = peak_draw;
        frame_next.peak_ok  = (peak_draw != 8'd0) && (peak_draw < limit);
        frame_next.hue_base = hue_new;

        held_peak_next = held_peak_reg;
        fall_cnt_next  = fall_cnt_reg;
        hue_base_next  = hue_base_reg;
        if (load)
        begin
            hue_base_next  = hue_new;
            held_peak_next = peak_draw;
            if (cfg_fall_en_reg)
            begin
                if (fall_cnt_inc >= {1'b0, cfg_fall_rate_reg})
                begin
                    held_peak_next = peak_draw - 8'(peak_draw != 8'd0);
                    fall_cnt_next  = 8'd0;
                end
                else
                begin
                    fall_cnt_next = fall_cnt_inc[7:0];
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    // per-LED colour
    lbvu_pixel #(
        .LED_COUNT (LED_COUNT)
    ) u_pixel (
        .pos   (pos_reg),
        .frame (frame_reg),
        .lit   (px_lit),
        .hue   (px_hue)
    );

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            active_reg     <= 1'b0;
            pos_reg        <= '0;
            out_valid_reg  <= 1'b0;
            held_peak_reg  <= 8'd0;
            fall_cnt_reg   <= 8'd0;
            hue_base_reg   <= lbvu_pkg::HUE_RESET;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            active_reg     <= active_next;
            pos_reg        <= pos_next;
            out_valid_reg  <= out_valid_next;
            held_peak_reg  <= held_peak_next;
            fall_cnt_reg   <= fall_cnt_next;
            hue_base_reg   <= hue_base_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            pend_height_reg <= lbvu_pkg::calc_height(s_tdata[9:0]);
            pend_tick_reg   <= s_tuser;
        end
        if (load)
            frame_reg <= frame_next;
        if (step)
        begin
            out_pos_reg  <= 6'(pos_reg);
            out_lit_reg  <= px_lit;
            out_hue_reg  <= px_hue;
            out_last_reg <= last_pos;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_hue_reg, out_pos_reg};
    assign m_tuser  = out_lit_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== rtl/core/lbvu_pixel.sv =====
// ---------------------------------------------------------------------------
// LED bar VU meter pixel
// Colour of one LED position from the current frame context.
// ---------------------------------------------------------------------------
module lbvu_pixel #(
    parameter int LED_COUNT = 64
) (
    input  logic [((LED_COUNT > 1) ? $clog2(LED_COUNT) : 1)-1:0] pos,
    input  lbvu_pkg::frame_t                                     frame,
    output logic                                                 lit,
    output logic [7:0]                                           hue
);

    localparam int PW   = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int HALF = LED_COUNT / 2;
    localparam bit ODD  = (LED_COUNT % 2) != 0;
    localparam logic [PW-1:0] HALF_P  = PW'(HALF);
    localparam logic [PW-1:0] HALF_M1 = PW'(HALF - 1);
    localparam logic [PW-1:0] LAST_P  = PW'(LED_COUNT - 1);

    logic [PW-1:0] led_dist;
    logic [7:0]    dist_ext;
    logic          on_strip;
    logic          bar_hit;
    logic          peak_hit;
    logic [7:0]    bar_hue;

    always_comb
    begin
        on_strip = 1'b1;
        if (frame.centred)
        begin
            // odd strip: the top LED sits outside both halves
            on_strip = !(ODD && (pos == LAST_P));
            led_dist = (pos < HALF_P) ? (HALF_M1 - pos) : (pos - HALF_P);
        end
        else
        begin
            led_dist = pos;
        end
        dist_ext = 8'(led_dist);
        bar_hit  = dist_ext < frame.height;
        peak_hit = frame.peak_ok && (frame.peak == dist_ext);
        bar_hue  = frame.hue_base + 8'(dist_ext * lbvu_pkg::HUE_STEP);

        lit = on_strip && (bar_hit || peak_hit);
        if (!on_strip)
            hue = 8'd0;
        else if (peak_hit)
            hue = frame.hue_base;
        else if (bar_hit)
            hue = bar_hue;
        else
            hue = 8'd0;
    end

endmodule

// ===== rtl/core/lbvu_checker.sv =====
// ---------------------------------------------------------------------------
// LED bar VU meter checker
// Port-level checks on the LED result stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "led_bar_vu_meter_peak_hold_unit_defines.svh"

module lbvu_checker #(
    parameter int LED_COUNT = 64
) (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    localparam logic [5:0] LAST_POS = 6'(LED_COUNT - 1);

    logic       out_take;
    logic       seen_reg;
    logic       prev_last_reg;
    logic [5:0] prev_pos_reg;
    logic [5:0] exp_pos;

    assign out_take = m_tvalid && m_tready;
    assign exp_pos  = prev_last_reg ? 6'd0 : (prev_pos_reg + 6'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= 1'b0;
            prev_last_reg <= 1'b1;
            prev_pos_reg  <= 6'd0;
        end
        else if (out_take)
        begin
            seen_reg      <= 1'b1;
            prev_last_reg <= m_tlast;
            prev_pos_reg  <= m_tdata[5:0];
        end
    end

    // stalled result holds
    `LBVU_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // end-of-frame mark sits exactly on the top LED
    `LBVU_ASSERT_NOW(a_last_pos, clk, rst_n, m_tvalid, m_tlast == (m_tdata[5:0] == LAST_POS))

    // LEDs come out in order, restarting at zero after each frame
    `LBVU_ASSERT_NOW(a_order, clk, rst_n, out_take && seen_reg, m_tdata[5:0] == exp_pos)

    // a dark LED carries zero hue
    `LBVU_ASSERT_NOW(a_dark_hue, clk, rst_n, m_tvalid && !m_tuser, m_tdata[13:6] == 8'd0)

endmodule

bind led_bar_vu_meter_peak_hold_unit lbvu_checker #(
    .LED_COUNT (LED_COUNT)
) u_lbvu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
